[design/assert_macros.svh]
// Assertion macros for the frame manager RTL.
// Included by the core module, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/cbfm_pkg.sv]
// Package for the clock buffer frame manager: codes, states, result type.
// No dependencies.
`timescale 1ns / 1ps
package cbfm_pkg;
  localparam int FileW = 8;
  localparam int PageW = 32;
  localparam int FrmOutW = 4;
  localparam int StatW = 3;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_UNPIN = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_EXCEEDED = 3'd1,
    ST_NOT_RES  = 3'd2,
    ST_NOT_PIN  = 3'd3,
    ST_PINNED   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,     // walk all frames: lookup, all-pinned, flush pinned check
    S_SCAN_END,
    S_HIT,
    S_SWEEP,
    S_UNPIN,
    S_FLUSH,
    S_FLUSH_END,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [FrmOutW-1:0] frame;
    logic               hit;
    logic               need_fetch;
    logic [StatW-1:0]   status;
    logic               wb_valid;
    logic [FileW-1:0]   wb_file;
    logic [PageW-1:0]   wb_page;
    logic               last;
  } result_t;
endpackage

[design/cbfm_desc_mem.sv]
// Descriptor memory: tags in a RAM, valid bits in flops, registered read.
// Depends on cbfm_pkg.
`timescale 1ns / 1ps
module cbfm_desc_mem #(
  parameter int NUM_FRAMES = 16,
  parameter int PIN_BITS = 8,
  localparam int IdxW = $clog2(NUM_FRAMES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IdxW-1:0]        rd_addr,
  output logic                   rd_valid,
  output logic                   rd_ref,
  output logic                   rd_dirty,
  output logic [PIN_BITS-1:0]    rd_pin,
  output logic [cbfm_pkg::FileW-1:0] rd_file,
  output logic [cbfm_pkg::PageW-1:0] rd_page,
  input  logic                   wr_en,
  input  logic [IdxW-1:0]        wr_addr,
  input  logic                   wr_valid,
  input  logic                   wr_ref,
  input  logic                   wr_dirty,
  input  logic [PIN_BITS-1:0]    wr_pin,
  input  logic                   wr_tags,
  input  logic [cbfm_pkg::FileW-1:0] wr_file,
  input  logic [cbfm_pkg::PageW-1:0] wr_page
);
  import cbfm_pkg::*;
  localparam int MetaW = 2 + PIN_BITS;

  logic [MetaW-1:0] meta_mem [NUM_FRAMES];
  logic [FileW+PageW-1:0] tag_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r;
  logic rd_v_r;
  logic [MetaW-1:0] meta_q;
  logic [FileW+PageW-1:0] tag_q;

  // Valid bits reset at once; ref, dirty and pin are masked by valid on read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      rd_v_r <= valid_r[rd_addr];
      if (wr_en) valid_r[wr_addr] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    meta_q <= meta_mem[rd_addr];
    tag_q  <= tag_mem[rd_addr];
    if (wr_en) begin
      meta_mem[wr_addr] <= {wr_ref, wr_dirty, wr_pin};
      if (wr_tags) tag_mem[wr_addr] <= {wr_file, wr_page};
    end
  end

  assign rd_valid = rd_v_r;
  assign rd_ref   = rd_v_r & meta_q[MetaW-1];
  assign rd_dirty = rd_v_r & meta_q[MetaW-2];
  assign rd_pin   = rd_v_r ? meta_q[PIN_BITS-1:0] : '0;
  assign rd_file  = tag_q[FileW+PageW-1:PageW];
  assign rd_page  = tag_q[PageW-1:0];
endmodule

[design/clock_buffer_frame_manager_core.sv]
// Top level of the clock buffer frame manager.
// Depends on cbfm_pkg, cbfm_desc_mem and assert_macros.svh.
`timescale 1ns / 1ps
// Frame manager for a buffer pool with clock replacement. Each request (read,
// allocate, unpin, flush) walks the descriptor memory in a synchronous RAM.
// Every request first scans all NUM_FRAMES descriptors, one per cycle, to find a
// tag match, check whether the sweep range is fully pinned and, for a flush,
// whether any frame of the file is pinned. A hit or an unpin of a resident page
// then re-reads and updates its frame. If the range is not fully pinned, a miss
// runs the clock sweep, at most twice the sweep span of visits; if no frame of
// the file is pinned, a flush walks all frames, stalls while a write-back result
// waits, and emits one result per dirty frame of the file plus a final one.
// Sweep and flush read then examine each frame. Results wait in an output register;
// a new request is taken only after the last result of the current one is taken.
// frames_in_use is sampled live; write it only while the block is idle.
module clock_buffer_frame_manager_core #(
  parameter int NUM_FRAMES = 16,
  parameter int PIN_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_file_id,
  input  logic [31:0] in_page_no,
  input  logic        in_set_dirty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_frame,
  output logic        out_hit,
  output logic        out_need_fetch,
  output logic [2:0]  out_status,
  output logic        out_wb_valid,
  output logic [7:0]  out_wb_file,
  output logic [31:0] out_wb_page,
  output logic        out_last
);
  import cbfm_pkg::*;
  `include "assert_macros.svh"

  localparam int IdxW = $clog2(NUM_FRAMES);
  localparam int CntW = $clog2(NUM_FRAMES + 1);
  localparam int SwW  = $clog2(2 * NUM_FRAMES + 2);
  localparam logic [PIN_BITS-1:0] PinMax = '1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FRAMES - 1);

  state_t state_r, state_nxt;
  logic [4:0] fiu_r;
  logic [IdxW-1:0] hand_r, hand_nxt;
  logic [1:0] mode_r;
  logic [FileW-1:0] file_r;
  logic [PageW-1:0] page_r;
  logic sd_r;
  logic [IdxW-1:0] ptr_r, ptr_nxt;      // address issued this cycle
  logic rdv_r, rdv_nxt;                 // read data returning this cycle
  logic [IdxW-1:0] rdi_r;               // index of returning data
  logic found_r, found_nxt;
  logic [IdxW-1:0] fidx_r, fidx_nxt;
  logic allpin_r, allpin_nxt;
  logic anypin_r, anypin_nxt;
  logic [SwW-1:0] steps_r, steps_nxt;
  logic phase_r, phase_nxt;             // 0 issue, 1 examine (hit, unpin, sweep, flush)
  logic flast_r, flast_nxt;             // flush walk reached last frame
  result_t res_r, res_nxt;
  logic ov_r, ov_nxt;

  logic [IdxW-1:0] rd_addr;
  logic rd_valid, rd_ref, rd_dirty;
  logic [PIN_BITS-1:0] rd_pin;
  logic [FileW-1:0] rd_file;
  logic [PageW-1:0] rd_page;
  logic wr_en, wr_valid, wr_ref, wr_dirty, wr_tags;
  logic [IdxW-1:0] wr_addr;
  logic [PIN_BITS-1:0] wr_pin;

  logic [CntW-1:0] span;
  logic tag_match, file_match, hand_wrap;
  logic [IdxW-1:0] hand_adv;

  // Effective sweep span: 0 counts as 1, clamp at NUM_FRAMES.
  always_comb begin
    if (fiu_r == '0) span = CntW'(1);
    else if (32'(fiu_r) > NUM_FRAMES) span = CntW'(NUM_FRAMES);
    else span = CntW'(fiu_r);
  end

  assign file_match = rd_valid && (rd_file == file_r);
  assign tag_match  = file_match && (rd_page == page_r);
  assign hand_wrap  = (32'(hand_r) + 1) >= 32'(span);
  assign hand_adv   = hand_wrap ? '0 : hand_r + 1'b1;

  cbfm_desc_mem #(.NUM_FRAMES(NUM_FRAMES), .PIN_BITS(PIN_BITS)) u_mem (
    .clk, .rst_n, .rd_addr, .rd_valid, .rd_ref, .rd_dirty, .rd_pin,
    .rd_file, .rd_page, .wr_en, .wr_addr, .wr_valid, .wr_ref, .wr_dirty,
    .wr_pin, .wr_tags, .wr_file(file_r), .wr_page(page_r)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_frame = res_r.frame;
  assign out_hit = res_r.hit;
  assign out_need_fetch = res_r.need_fetch;
  assign out_status = res_r.status;
  assign out_wb_valid = res_r.wb_valid;
  assign out_wb_file = res_r.wb_file;
  assign out_wb_page = res_r.wb_page;
  assign out_last = res_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fiu_r   <= 5'd16;
      hand_r  <= LastIdx;
      ov_r    <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      ov_r    <= ov_nxt;
      rdv_r   <= rdv_nxt;
      if (cfg_we) fiu_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    rdi_r <= rd_addr;
    found_r <= found_nxt;
    fidx_r <= fidx_nxt;
    allpin_r <= allpin_nxt;
    anypin_r <= anypin_nxt;
    steps_r <= steps_nxt;
    phase_r <= phase_nxt;
    flast_r <= flast_nxt;
    res_r <= res_nxt;
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      file_r <= in_file_id;
      page_r <= in_page_no;
      sd_r   <= in_set_dirty;
    end
  end

  always_comb begin
    state_nxt = state_r;
    hand_nxt = hand_r;
    ptr_nxt = ptr_r;
    rdv_nxt = 1'b0;
    rd_addr = ptr_r;
    found_nxt = found_r;
    fidx_nxt = fidx_r;
    allpin_nxt = allpin_r;
    anypin_nxt = anypin_r;
    steps_nxt = steps_r;
    phase_nxt = phase_r;
    flast_nxt = flast_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    wr_en = 1'b0;
    wr_addr = rdi_r;
    wr_valid = 1'b1;
    wr_ref = rd_ref;
    wr_dirty = rd_dirty;
    wr_pin = rd_pin;
    wr_tags = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
          ptr_nxt = (NUM_FRAMES > 1) ? IdxW'(1) : '0;
          rdv_nxt = 1'b1;
          found_nxt = 1'b0;
          allpin_nxt = 1'b1;
          anypin_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        // Issue next address while checking the returning descriptor.
        if (rdv_r) begin
          if (tag_match && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt = rdi_r;
          end
          if ((32'(rdi_r) < 32'(span)) && (!rd_valid || rd_pin == '0))
            allpin_nxt = 1'b0;
          if (file_match && rd_pin != '0) anypin_nxt = 1'b1;
        end
        if (rd_addr == LastIdx && !(rdv_r && rdi_r == LastIdx)) begin
          rdv_nxt = 1'b1;
          state_nxt = S_SCAN_END;
        end else begin
          rdv_nxt = 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_SCAN_END: begin
        // Last descriptor returns this cycle.
        if (tag_match && !found_r) begin
          found_nxt = 1'b1;
          fidx_nxt = rdi_r;
        end
        if ((32'(rdi_r) < 32'(span)) && (!rd_valid || rd_pin == '0))
          allpin_nxt = 1'b0;
        if (file_match && rd_pin != '0) anypin_nxt = 1'b1;
        case (mode_t'(mode_r))
          MODE_FLUSH: begin
            if (anypin_r || (file_match && rd_pin != '0)) begin
              res_nxt = '0;
              res_nxt.status = ST_PINNED;
              res_nxt.last = 1'b1;
              ov_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_FLUSH;
              ptr_nxt = '0;
              phase_nxt = 1'b0;
              flast_nxt = 1'b0;
            end
          end
          MODE_UNPIN: begin
            if (found_r || tag_match) begin
              ptr_nxt = found_r ? fidx_r : rdi_r;
              state_nxt = S_UNPIN;
              phase_nxt = 1'b0;
            end else begin
              res_nxt = '0;
              res_nxt.status = ST_NOT_RES;
              res_nxt.last = 1'b1;
              ov_nxt = 1'b1;
              state_nxt = S_OUT;
            end
          end
          default: begin
            if (found_r || tag_match) begin
              ptr_nxt = found_r ? fidx_r : rdi_r;
              state_nxt = S_HIT;
              phase_nxt = 1'b0;
            end else if (allpin_nxt) begin
              res_nxt = '0;
              res_nxt.status = ST_EXCEEDED;
              res_nxt.last = 1'b1;
              ov_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_SWEEP;
              phase_nxt = 1'b0;
              steps_nxt = '0;
            end
          end
        endcase
      end
      S_HIT, S_UNPIN: begin
        rd_addr = ptr_r;
        if (!phase_r) begin
          rdv_nxt = 1'b1;
          phase_nxt = 1'b1;
        end else begin
          wr_en = 1'b1;
          res_nxt = '0;
          res_nxt.frame = FrmOutW'(rdi_r);
          res_nxt.last = 1'b1;
          if (state_r == S_HIT) begin
            wr_ref = 1'b1;
            if (rd_pin != PinMax) wr_pin = rd_pin + 1'b1;
            res_nxt.hit = 1'b1;
          end else if (rd_pin == '0) begin
            wr_en = 1'b0;
            res_nxt.status = ST_NOT_PIN;
          end else begin
            wr_dirty = rd_dirty | sd_r;
            wr_pin = rd_pin - 1'b1;
          end
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SWEEP: begin
        if (!phase_r) begin
          hand_nxt = hand_adv;
          rd_addr = hand_adv;
          rdv_nxt = 1'b1;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          steps_nxt = steps_r + 1'b1;
          if (rd_valid && rd_ref) begin
            wr_en = 1'b1;
            wr_ref = 1'b0;
          end else if (rd_valid && rd_pin != '0) begin
            wr_en = 1'b0;
          end else begin
            // Victim taken.
            wr_en = 1'b1;
            wr_tags = 1'b1;
            wr_ref = 1'b1;
            wr_dirty = 1'b0;
            wr_pin = PIN_BITS'(1);
            res_nxt = '0;
            res_nxt.frame = FrmOutW'(rdi_r);
            res_nxt.need_fetch = (mode_t'(mode_r) == MODE_READ);
            res_nxt.wb_valid = rd_dirty;
            res_nxt.wb_file = rd_dirty ? rd_file : '0;
            res_nxt.wb_page = rd_dirty ? rd_page : '0;
            res_nxt.last = 1'b1;
            ov_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_FLUSH: begin
        // Stall while a write-back result is still waiting.
        if (!phase_r) begin
          rd_addr = ptr_r;
          rdv_nxt = 1'b1;
          phase_nxt = 1'b1;
          flast_nxt = (ptr_r == LastIdx);
        end else if (!ov_r || out_ready || !(file_match && rd_dirty)) begin
          if (file_match) begin
            wr_en = 1'b1;
            wr_valid = 1'b0;
            wr_ref = 1'b0;
            wr_dirty = 1'b0;
            wr_pin = '0;
            if (rd_dirty) begin
              res_nxt = '0;
              res_nxt.frame = FrmOutW'(rdi_r);
              res_nxt.wb_valid = 1'b1;
              res_nxt.wb_file = rd_file;
              res_nxt.wb_page = rd_page;
              ov_nxt = 1'b1;
            end
          end
          phase_nxt = 1'b0;
          ptr_nxt = ptr_r + 1'b1;
          if (flast_r) state_nxt = S_FLUSH_END;
        end else begin
          // Hold the read data by re-reading the same entry.
          rd_addr = rdi_r;
          rdv_nxt = 1'b1;
        end
      end
      S_FLUSH_END: begin
        if (!ov_r || out_ready) begin
          res_nxt = '0;
          res_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (ov_r && out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Checks.
  `ASSERT_IMP(a_busy_no_accept, clk, rst_n, state_r != S_IDLE, !in_ready,
              "request accepted while busy")
  `ASSERT_IMP(a_hand_range, clk, rst_n, 1'b1, 32'(hand_r) < NUM_FRAMES,
              "clock hand out of range")
  `ASSERT_NXT(a_out_done, clk, rst_n, state_r == S_OUT && ov_r && out_ready,
              state_r == S_IDLE && !ov_r, "final result not retired")
  `ASSERT_IMP(a_last_in_out, clk, rst_n, ov_r && res_r.last, state_r == S_OUT,
              "last result outside final state")
endmodule

[tb/sv/clock_buffer_frame_manager_core_test.sv]
// Self-checking bench for the clock buffer frame manager core.
// Depends on cbfm_pkg and clock_buffer_frame_manager_core; drives requests,
// predicts every result with a behavioral buffer-pool model and compares.
`timescale 1ns / 1ps
module clock_buffer_frame_manager_core_test;
  import cbfm_pkg::*;

  localparam int NFRM = 16;
  localparam int PMAX = 255;
  localparam int TAIL = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  file_id;
    logic [31:0] page_no;
    logic        set_dirty;
  } request_t;

  // directed row: request, plus an optional typed-in answer for one-result ops
  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [4:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_mode = 0;
  logic [7:0] in_file_id = 0;
  logic [31:0] in_page_no = 0;
  logic in_set_dirty = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [3:0] out_frame;
  logic out_hit, out_need_fetch, out_wb_valid, out_last;
  logic [2:0] out_status;
  logic [7:0] out_wb_file;
  logic [31:0] out_wb_page;

  always #10 clk = ~clk;

  clock_buffer_frame_manager_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_file_id(in_file_id), .in_page_no(in_page_no), .in_set_dirty(in_set_dirty),
    .out_valid(out_valid), .out_ready(out_ready), .out_frame(out_frame),
    .out_hit(out_hit), .out_need_fetch(out_need_fetch), .out_status(out_status),
    .out_wb_valid(out_wb_valid), .out_wb_file(out_wb_file),
    .out_wb_page(out_wb_page), .out_last(out_last)
  );

  // ---------------- pool model ----------------
  bit          pool_valid [NFRM];
  bit          pool_ref [NFRM];
  bit          pool_dirty [NFRM];
  int unsigned pool_pins [NFRM];
  logic [7:0]  pool_file [NFRM];
  logic [31:0] pool_page [NFRM];
  int unsigned hand;
  logic [4:0]  span_reg;

  result_t pending_results[$];
  int errors = 0;
  int table_errors = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 55;
  int hold_req = 0;    // bumped by the sequence to ask for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;   // cycles the receiver must stay stalled

  function automatic int unsigned sweep_span();
    if (span_reg == 0) return 1;
    if (span_reg > NFRM) return NFRM;
    return span_reg;
  endfunction

  function automatic int find_page(logic [7:0] f, logic [31:0] p);
    for (int i = 0; i < NFRM; i++)
      if (pool_valid[i] && pool_file[i] == f && pool_page[i] == p) return i;
    return -1;
  endfunction

  function automatic result_t blank_result(status_t st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // clock sweep; -1 when every frame in range is valid and pinned
  function automatic int pick_victim();
    int unsigned n;
    bit jammed;
    n = sweep_span();
    jammed = 1;
    for (int i = 0; i < n; i++)
      if (!pool_valid[i] || pool_pins[i] == 0) jammed = 0;
    if (jammed) return -1;
    for (int s = 0; s <= 2 * n; s++) begin
      hand = (hand + 1 >= n) ? 0 : hand + 1;
      if (!pool_valid[hand]) return hand;
      if (pool_ref[hand]) begin
        pool_ref[hand] = 0;
        continue;
      end
      if (pool_pins[hand] > 0) continue;
      return hand;
    end
    return -1;
  endfunction

  // applies one request to the pool and queues the results it causes
  function automatic void predict_request(request_t q);
    result_t r;
    int fr;
    r = blank_result(ST_OK);
    if (q.mode == MODE_READ || q.mode == MODE_ALLOC) begin
      fr = find_page(q.file_id, q.page_no);
      if (fr >= 0) begin
        pool_ref[fr] = 1;
        if (pool_pins[fr] < PMAX) pool_pins[fr]++;
        r.frame = 4'(fr);
        r.hit = 1;
      end else begin
        fr = pick_victim();
        if (fr < 0) begin
          r.status = ST_EXCEEDED;
        end else begin
          if (pool_valid[fr] && pool_dirty[fr]) begin
            r.wb_valid = 1;
            r.wb_file = pool_file[fr];
            r.wb_page = pool_page[fr];
          end
          pool_valid[fr] = 1;
          pool_ref[fr] = 1;
          pool_dirty[fr] = 0;
          pool_pins[fr] = 1;
          pool_file[fr] = q.file_id;
          pool_page[fr] = q.page_no;
          r.frame = 4'(fr);
          r.need_fetch = (q.mode == MODE_READ);
        end
      end
      pending_results.push_back(r);
    end else if (q.mode == MODE_UNPIN) begin
      fr = find_page(q.file_id, q.page_no);
      if (fr < 0) begin
        r.status = ST_NOT_RES;
      end else begin
        r.frame = 4'(fr);
        if (pool_pins[fr] == 0) r.status = ST_NOT_PIN;
        else begin
          pool_dirty[fr] = pool_dirty[fr] | q.set_dirty;
          pool_pins[fr]--;
        end
      end
      pending_results.push_back(r);
    end else begin
      for (int i = 0; i < NFRM; i++)
        if (pool_valid[i] && pool_file[i] == q.file_id && pool_pins[i] > 0) begin
          pending_results.push_back(blank_result(ST_PINNED));
          return;
        end
      for (int i = 0; i < NFRM; i++)
        if (pool_valid[i] && pool_file[i] == q.file_id) begin
          if (pool_dirty[i]) begin
            r = '0;
            r.frame = 4'(i);
            r.wb_valid = 1;
            r.wb_file = pool_file[i];
            r.wb_page = pool_page[i];
            pending_results.push_back(r);
          end
          pool_valid[i] = 0;
          pool_ref[i] = 0;
          pool_dirty[i] = 0;
          pool_pins[i] = 0;
        end
      pending_results.push_back(blank_result(ST_OK));
    end
  endfunction

  // ---------------- result checking ----------------
  // sampled at the edge; outputs are stable here since inputs change via NBA
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_frame, out_hit, out_need_fetch, out_status, out_wb_valid,
              out_wb_file, out_wb_page, out_last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.frame !== want.frame) begin
          $display("%0t: frame expected %0d actual %0d", $time, want.frame, got.frame);
          errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.need_fetch !== want.need_fetch) begin
          $display("%0t: need_fetch expected %0d actual %0d", $time,
                   want.need_fetch, got.need_fetch);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.wb_valid !== want.wb_valid) begin
          $display("%0t: wb_valid expected %0d actual %0d", $time,
                   want.wb_valid, got.wb_valid);
          errors++;
        end
        if (got.wb_file !== want.wb_file) begin
          $display("%0t: wb_file expected %h actual %h", $time, want.wb_file, got.wb_file);
          errors++;
        end
        if (got.wb_page !== want.wb_page) begin
          $display("%0t: wb_page expected %h actual %h", $time, want.wb_page, got.wb_page);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------- stimulus helpers ----------------
  // offers one request and waits for its acceptance
  task automatic send_request(request_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= q.mode;
    in_file_id <= q.file_id;
    in_page_no <= q.page_no;
    in_set_dirty <= q.set_dirty;
    do @(posedge clk); while (!in_ready);
    predict_request(q);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once nothing is expected and the tail of the walk is over
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_span(logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_reg = v;
  endtask

  function automatic request_t make_req(mode_t m, logic [7:0] f, logic [31:0] p,
                                        logic d);
    request_t q;
    q.mode = m;
    q.file_id = f;
    q.page_no = p;
    q.set_dirty = d;
    return q;
  endfunction

  // well-formed traffic over a small working set so hits, evictions,
  // dirty write-backs and flushes all occur
  function automatic request_t random_req();
    logic [7:0] f;
    logic [31:0] p;
    int unsigned pick;
    pick = $urandom_range(99);
    f = 8'($urandom_range(3));
    p = $urandom_range(11);
    if ($urandom_range(9) == 0) f = 8'($urandom);
    if ($urandom_range(9) == 0) p = $urandom;
    if (pick < 40) return make_req(MODE_READ, f, p, 1'($urandom_range(1)));
    if (pick < 55) return make_req(MODE_ALLOC, f, p, 1'($urandom_range(1)));
    if (pick < 90) return make_req(MODE_UNPIN, f, p, 1'($urandom_range(1)));
    return make_req(MODE_FLUSH, f, p, 1'($urandom_range(1)));
  endfunction

  // ---------------- directed table ----------------
  row_t directed[$];

  task automatic add_row(mode_t m, logic [7:0] f, logic [31:0] p, logic d,
                         bit typed = 0, result_t r = '0);
    row_t w;
    w.req = make_req(m, f, p, d);
    w.typed = typed;
    w.res = r;
    directed.push_back(w);
  endtask

  task automatic build_directed();
    result_t r;
    // fresh pool: nothing resident, nothing to flush
    add_row(MODE_UNPIN, 8'h00, 32'h0, 1'b0, 1, blank_result(ST_NOT_RES));
    r = blank_result(ST_OK);
    add_row(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1, r);
    // first miss after reset: hand wraps from the last frame to frame 0
    r.need_fetch = 1;
    add_row(MODE_READ, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1, r);
    r = blank_result(ST_OK);
    r.frame = 0;
    r.hit = 1;
    add_row(MODE_READ, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1, r);
    add_row(MODE_ALLOC, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1, r);
    add_row(MODE_ALLOC, 8'h00, 32'h0, 1'b1);
    add_row(MODE_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_row(MODE_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    // flush refused while a pin remains
    add_row(MODE_FLUSH, 8'hFF, 32'h0, 1'b0, 1, blank_result(ST_PINNED));
    add_row(MODE_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_row(MODE_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b0); // not pinned any more
    add_row(MODE_FLUSH, 8'hFF, 32'h1234, 1'b0);     // write-back then final
    add_row(MODE_UNPIN, 8'h00, 32'h0, 1'b1);
    add_row(MODE_READ, 8'h00, 32'h5555_AAAA, 1'b0);
    add_row(MODE_READ, 8'hAA, 32'hAAAA_5555, 1'b0);
    add_row(MODE_READ, 8'h55, 32'h0000_0001, 1'b0);
    add_row(MODE_FLUSH, 8'h00, 32'h0, 1'b0);
  endtask

  // ---------------- main sequence ----------------
  initial begin
    request_t q;
    logic [4:0] span_plan[6];
    span_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17};
    span_reg = 5'd16;
    for (int i = 0; i < NFRM; i++) begin
      pool_valid[i] = 0; pool_ref[i] = 0; pool_dirty[i] = 0; pool_pins[i] = 0;
      pool_file[i] = '0; pool_page[i] = '0;
    end
    hand = NFRM - 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (directed[i]) begin
      send_request(directed[i].req);
      // final result of the row is the newest entry of the queue
      if (directed[i].typed && pending_results[$] !== directed[i].res) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i,
                 directed[i].res, pending_results[$]);
        table_errors++;
      end
    end
    drain();

    // fill the pool with pins so the sweep range jams, in a small range
    write_span(5'd2);
    send_request(make_req(MODE_READ, 8'h10, 32'd1, 1'b0));
    send_request(make_req(MODE_READ, 8'h10, 32'd2, 1'b0));
    send_request(make_req(MODE_ALLOC, 8'h10, 32'd3, 1'b0)); // buffer exceeded
    drain();
    // saturate one pin count
    send_idle_pct = 0;
    for (int i = 0; i < PMAX + 1; i++)
      send_request(make_req(MODE_READ, 8'h10, 32'd1, 1'b0));
    drain();

    // random phases across span settings and idle profiles
    for (int ph = 0; ph < 6; ph++) begin
      write_span(span_plan[ph]);
      if (ph < 2) begin send_idle_pct = 13; recv_idle_pct = 55; end
      else if (ph < 4) begin send_idle_pct = 55; recv_idle_pct = 13; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 1) hold_req++;   // long stall: block backs up
      for (int n = 0; n < 10; n++) begin
        q = random_req();
        send_request(q);
        if (n == 5) while (pending_results.size() != 0) @(posedge clk);
      end
      drain();
    end

    if (errors == 0 && table_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
